// ----- rtl/dertlv_pkg.sv -----
package dertlv_pkg;

    // Default sizing of the parser.
    localparam int OFFSET_BITS_DEF       = 16;
    localparam int MAX_TAG_OCTETS_DEF    = 4;
    localparam int MAX_LENGTH_OCTETS_DEF = 8;

    // Fixed field widths of the result beat.
    localparam int TAG_W    = 32;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_END     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    // Octet masks used by the tag and length rules.
    localparam logic [BYTE_W-1:0] TAG_MORE_MASK = 8'h1f;
    localparam logic [BYTE_W-1:0] LOW7_MASK     = 8'h7f;
    localparam logic [BYTE_W-1:0] HIGH_BIT_MASK = 8'h80;
    localparam int                LONG_MIN      = 128;

endpackage

// ----- rtl/der_tlv_stream_parser.sv -----
// Registered output: a result beat appears on the master side in the cycle after its input beat.
// Throughput: one input beat per cycle, sustained, as long as the master side keeps taking results.
// The single result register is the only buffer; the slave side stalls only while it is full and unread.
// Reset: synchronous, active low on i_rst_n; the parser waits for the first tag octet at offset zero.
// An end-of-buffer beat also returns the parser to that reset state for the next buffer.
module der_tlv_stream_parser #(
    parameter int OFFSET_BITS       = dertlv_pkg::OFFSET_BITS_DEF,
    parameter int MAX_TAG_OCTETS    = dertlv_pkg::MAX_TAG_OCTETS_DEF,
    parameter int MAX_LENGTH_OCTETS = dertlv_pkg::MAX_LENGTH_OCTETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] command (1 = end of buffer)
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [31:0] tag, [47:32] val_len,
                                        // [63:48] value_offset, [79:64] total_len
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int OB      = OFFSET_BITS;
    localparam int TCNT_W  = $clog2(MAX_TAG_OCTETS + 1);
    localparam int LCNT_W  = $clog2(MAX_LENGTH_OCTETS + 1);
    localparam int EXT_W   = (OB + 1 > dertlv_pkg::FIELD_W) ? OB + 1 : dertlv_pkg::FIELD_W;
    localparam int BW      = dertlv_pkg::BYTE_W;
    localparam int TW      = dertlv_pkg::TAG_W;
    localparam int FW      = dertlv_pkg::FIELD_W;

    // Parse phase, one-hot. PH_DEAD is entered after an INVALID result and
    // swallows data beats until the end-of-buffer beat.
    typedef enum logic [5:0] {
        PH_TAG_FIRST = 6'b000001,
        PH_TAG_MORE  = 6'b000010,
        PH_LEN_FIRST = 6'b000100,
        PH_LEN_MORE  = 6'b001000,
        PH_VALUE     = 6'b010000,
        PH_DEAD      = 6'b100000
    } t_phase;

    // Parser state. r_pos carries one extra bit so that running past the
    // offset range can be seen as a set top bit.
    t_phase              r_phase,     n_phase;
    logic [OB:0]         r_pos,       n_pos;
    logic [OB-1:0]       r_rec_start, n_rec_start;
    logic [OB-1:0]       r_val_start, n_val_start;
    logic [OB-1:0]       r_len,       n_len;
    logic [OB-1:0]       r_val_left,  n_val_left;
    logic [TW-1:0]       r_tag,       n_tag;
    logic [TCNT_W-1:0]   r_tag_cnt,   n_tag_cnt;
    logic [LCNT_W-1:0]   r_len_left,  n_len_left;
    logic                r_len_first, n_len_first;

    // Result register.
    logic                r_out_valid;
    logic [1:0]          r_out_status, n_out_status;
    logic [TW-1:0]       r_out_tag,    n_out_tag;
    logic [FW-1:0]       r_out_vlen,   n_out_vlen;
    logic [FW-1:0]       r_out_voff,   n_out_voff;
    logic [FW-1:0]       r_out_elen,   n_out_elen;

    logic                w_accept;
    logic                w_emit;
    logic                w_emit_rec;
    logic [BW-1:0]       w_byte;
    logic [OB:0]         w_pos_inc;
    logic [OB:0]         w_elen;
    logic [OB+BW-1:0]    w_len_shift;
    logic [6:0]          w_len_cnt;
    logic [EXT_W-1:0]    w_elen_ext;
    logic [EXT_W-1:0]    w_vlen_ext;
    logic [EXT_W-1:0]    w_voff_ext;

    // The result register parts the two sides: a new byte is taken whenever
    // the register is empty or is being emptied in this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_byte        = s_axis_tdata;

    assign w_pos_inc   = r_pos + {{OB{1'b0}}, 1'b1};
    // Encoded length spans from the first tag octet through the current byte.
    assign w_elen      = w_pos_inc - {1'b0, r_rec_start};
    // Long-form length accumulation; the top byte of the concatenation is
    // the part that would fall off the offset range.
    assign w_len_shift = {r_len, w_byte};
    assign w_len_cnt   = w_byte[6:0];

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_rec_start  = r_rec_start;
        n_val_start  = r_val_start;
        n_len        = r_len;
        n_val_left   = r_val_left;
        n_tag        = r_tag;
        n_tag_cnt    = r_tag_cnt;
        n_len_left   = r_len_left;
        n_len_first  = r_len_first;
        w_emit       = 1'b0;
        w_emit_rec   = 1'b0;
        n_out_status = dertlv_pkg::ST_INVALID;

        if (s_axis_tuser) begin
            // End of buffer: report END at a record boundary, INVALID inside
            // a record, and nothing after an earlier INVALID.
            n_phase = PH_TAG_FIRST;
            n_pos   = '0;
            if (r_phase == PH_TAG_FIRST) begin
                w_emit       = 1'b1;
                n_out_status = dertlv_pkg::ST_END;
            end else if (r_phase != PH_DEAD) begin
                w_emit = 1'b1;
            end
        end else if (r_phase != PH_DEAD) begin
            if (r_pos[OB]) begin
                // This byte would sit beyond the offset range.
                n_phase = PH_DEAD;
                w_emit  = 1'b1;
            end else begin
                n_pos = w_pos_inc;
                case (r_phase)
                    PH_TAG_FIRST: begin
                        n_rec_start = r_pos[OB-1:0];
                        n_tag       = TW'(w_byte);
                        n_tag_cnt   = TCNT_W'(1);
                        n_len       = '0;
                        if ((w_byte & dertlv_pkg::TAG_MORE_MASK) ==
                                dertlv_pkg::TAG_MORE_MASK) begin
                            n_phase = PH_TAG_MORE;
                        end else begin
                            n_phase = PH_LEN_FIRST;
                        end
                    end
                    PH_TAG_MORE: begin
                        // DER forbids a first continuation octet with no
                        // tag number bits set.
                        if (r_tag_cnt >= TCNT_W'(MAX_TAG_OCTETS) ||
                            (r_tag_cnt == TCNT_W'(1) &&
                             (w_byte & dertlv_pkg::LOW7_MASK) == '0)) begin
                            n_phase = PH_DEAD;
                            w_emit  = 1'b1;
                        end else begin
                            n_tag     = {r_tag[TW-BW-1:0], w_byte};
                            n_tag_cnt = r_tag_cnt + TCNT_W'(1);
                            if ((w_byte & dertlv_pkg::HIGH_BIT_MASK) == '0) begin
                                n_phase = PH_LEN_FIRST;
                            end
                        end
                    end
                    PH_LEN_FIRST: begin
                        if ((w_byte & dertlv_pkg::HIGH_BIT_MASK) == '0) begin
                            // Short form: the header ends with this byte.
                            n_len = OB'(w_byte);
                            if (w_pos_inc[OB]) begin
                                n_phase = PH_DEAD;
                                w_emit  = 1'b1;
                            end else begin
                                n_val_start = w_pos_inc[OB-1:0];
                                if (w_byte == '0) begin
                                    n_phase      = PH_TAG_FIRST;
                                    w_emit       = 1'b1;
                                    w_emit_rec   = 1'b1;
                                    n_out_status = dertlv_pkg::ST_OK;
                                end else begin
                                    n_val_left = OB'(w_byte);
                                    n_phase    = PH_VALUE;
                                end
                            end
                        end else if (w_len_cnt == '0 ||
                                     w_len_cnt > 7'(MAX_LENGTH_OCTETS)) begin
                            n_phase = PH_DEAD;
                            w_emit  = 1'b1;
                        end else begin
                            n_len_left  = LCNT_W'(w_len_cnt);
                            n_len_first = 1'b1;
                            n_len       = '0;
                            n_phase     = PH_LEN_MORE;
                        end
                    end
                    PH_LEN_MORE: begin
                        // Leading zero octet, or a length that outgrows the
                        // offset range, breaks the encoding.
                        if ((r_len_first && w_byte == '0) ||
                            w_len_shift[OB+BW-1:OB] != '0) begin
                            n_phase = PH_DEAD;
                            w_emit  = 1'b1;
                        end else begin
                            n_len_first = 1'b0;
                            n_len       = w_len_shift[OB-1:0];
                            n_len_left  = r_len_left - LCNT_W'(1);
                            if (r_len_left == LCNT_W'(1)) begin
                                // Long form must not encode a short length;
                                // a nonzero value is guaranteed past this.
                                if (w_len_shift[OB-1:0] < OB'(dertlv_pkg::LONG_MIN) ||
                                    w_pos_inc[OB]) begin
                                    n_phase = PH_DEAD;
                                    w_emit  = 1'b1;
                                end else begin
                                    n_val_start = w_pos_inc[OB-1:0];
                                    n_val_left  = w_len_shift[OB-1:0];
                                    n_phase     = PH_VALUE;
                                end
                            end
                        end
                    end
                    PH_VALUE: begin
                        n_val_left = r_val_left - OB'(1);
                        if (r_val_left == OB'(1)) begin
                            n_phase      = PH_TAG_FIRST;
                            w_emit       = 1'b1;
                            w_emit_rec   = 1'b1;
                            n_out_status = dertlv_pkg::ST_OK;
                        end
                    end
                    default: begin
                        n_phase = PH_DEAD;
                        w_emit  = 1'b1;
                    end
                endcase
            end
        end
    end

    // Result payload: record fields for OK, zeros for END and INVALID.
    assign w_elen_ext = EXT_W'(w_elen);
    assign w_vlen_ext = EXT_W'(n_len);
    assign w_voff_ext = EXT_W'(n_val_start);

    always_comb begin
        if (w_emit_rec) begin
            n_out_tag  = n_tag;
            n_out_vlen = w_vlen_ext[FW-1:0];
            n_out_voff = w_voff_ext[FW-1:0];
            n_out_elen = w_elen_ext[FW-1:0];
        end else begin
            n_out_tag  = '0;
            n_out_vlen = '0;
            n_out_voff = '0;
            n_out_elen = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG_FIRST;
            r_pos       <= '0;
            r_len_first <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_len_first <= n_len_first;
            end
            if (w_accept && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; each record rewrites them before use.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rec_start <= n_rec_start;
            r_val_start <= n_val_start;
            r_len       <= n_len;
            r_val_left  <= n_val_left;
            r_tag       <= n_tag;
            r_tag_cnt   <= n_tag_cnt;
            r_len_left  <= n_len_left;
        end
        if (w_accept && w_emit) begin
            r_out_status <= n_out_status;
            r_out_tag    <= n_out_tag;
            r_out_vlen   <= n_out_vlen;
            r_out_voff   <= n_out_voff;
            r_out_elen   <= n_out_elen;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_elen, r_out_voff, r_out_vlen, r_out_tag};
    assign m_axis_tuser  = r_out_status;

endmodule

// ----- test/tb_der_tlv_stream_parser.sv -----
module tb_der_tlv_stream_parser;

    // Sizing of the parser under test, taken from the package defaults.
    localparam int OFS_W   = dertlv_pkg::OFFSET_BITS_DEF;
    localparam int OFS_MAX = (1 << OFS_W) - 1;
    localparam int MAX_TAG = dertlv_pkg::MAX_TAG_OCTETS_DEF;
    localparam int MAX_LEN = dertlv_pkg::MAX_LENGTH_OCTETS_DEF;

    // Where the parser stands within a record.
    typedef enum logic [2:0] {
        P_TAG0,     // waiting for the first tag octet of a record
        P_TAGN,     // collecting tag continuation octets
        P_LEN0,     // waiting for the first length octet
        P_LENN,     // collecting long-form length octets
        P_VALUE,    // counting value bytes
        P_DEAD      // after a rule break, until the end marker
    } t_prs_phase;

    // One result beat, unpacked into its fields.
    typedef struct packed {
        logic [dertlv_pkg::STATUS_W-1:0] status;
        logic [dertlv_pkg::TAG_W-1:0]    tag;
        logic [dertlv_pkg::FIELD_W-1:0]  vlen;
        logic [dertlv_pkg::FIELD_W-1:0]  voff;
        logic [dertlv_pkg::FIELD_W-1:0]  enc;
    } t_tlv_rec;

    // One pending input beat. A hold entry sends nothing: the sender waits
    // at it until every expected record has come out.
    typedef struct packed {
        bit          hold;
        logic        is_end;
        logic [7:0]  data;
    } t_in_beat;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;     // [7:0] data_byte
    logic         s_axis_tuser;     // [0] command (1 = end of buffer)
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;     // [31:0] tag, [47:32] val_len,
                                    // [63:48] value_offset, [79:64] total_len
    logic [1:0]   m_axis_tuser;     // [1:0] status

    der_tlv_stream_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_in_beat   pending_q[$];   // input beats not yet offered to the parser
    t_tlv_rec   record_q[$];    // records the parser still owes us
    int         err_count  = 0;
    int         res_count  = 0;
    int         live_items = 0;
    bit         counting   = 1'b1;
    bit         in_taken   = 1'b0;
    int         cyc_count  = 0;

    // During this window of cycles neither side idles, so the parser also
    // runs at its full rate for a while.
    wire calm = (cyc_count >= 1500) && (cyc_count < 2300);

    // ------------------------------------------------------------------
    // Predictor state: a private copy of what the parser keeps.
    // ------------------------------------------------------------------
    t_prs_phase                     ph;
    logic [dertlv_pkg::TAG_W-1:0]   cur_tag;
    logic [2:0]                     tag_cnt;
    logic [dertlv_pkg::FIELD_W-1:0] len_acc;
    logic [3:0]                     len_left;
    bit                             len_first;
    logic [OFS_W:0]                 pos_next;   // one bit wider so an overrun is visible
    logic [OFS_W:0]                 rec_base;
    logic [OFS_W:0]                 val_base;
    logic [dertlv_pkg::FIELD_W-1:0] val_left;

    function automatic void reset_parser();
        ph        = P_TAG0;
        cur_tag   = '0;
        tag_cnt   = '0;
        len_acc   = '0;
        len_left  = '0;
        len_first = 1'b0;
        pos_next  = '0;
        rec_base  = '0;
        val_base  = '0;
        val_left  = '0;
    endfunction

    // A rule break: one INVALID beat, then silence until the end marker.
    function automatic bit kill_buffer(output t_tlv_rec r);
        ph       = P_DEAD;
        r        = '0;
        r.status = dertlv_pkg::ST_INVALID;
        return 1'b1;
    endfunction

    function automatic bit close_record(input logic [OFS_W:0] pos, output t_tlv_rec r);
        logic [OFS_W:0] span;
        span     = pos + 1'b1 - rec_base;
        ph       = P_TAG0;
        r.status = dertlv_pkg::ST_OK;
        r.tag    = cur_tag;
        r.vlen   = len_acc;
        r.voff   = val_base[dertlv_pkg::FIELD_W-1:0];
        r.enc    = span[dertlv_pkg::FIELD_W-1:0];
        return 1'b1;
    endfunction

    // The byte at pos completed the length field.
    function automatic bit header_end(input logic [OFS_W:0] pos, output t_tlv_rec r);
        val_base = pos + 1'b1;
        r        = '0;
        if (val_base > OFS_MAX) return kill_buffer(r);
        if (len_acc == 0) return close_record(pos, r);
        val_left = len_acc;
        ph       = P_VALUE;
        return 1'b0;
    endfunction

    // Advances the predictor by one input beat. Returns 1 when the beat
    // makes the parser emit a result, which is then left in r.
    function automatic bit parse_beat(input logic is_end, input logic [7:0] b,
                                      output t_tlv_rec r);
        t_prs_phase     was;
        logic [OFS_W:0] pos;
        logic [7:0]     n;
        r = '0;
        if (is_end) begin
            was = ph;
            reset_parser();
            if (was == P_TAG0) begin
                r.status = dertlv_pkg::ST_END;
                return 1'b1;
            end
            if (was == P_DEAD) return 1'b0;
            r.status = dertlv_pkg::ST_INVALID;
            return 1'b1;
        end
        if (ph == P_DEAD) return 1'b0;
        pos = pos_next;
        if (pos > OFS_MAX) return kill_buffer(r);
        pos_next = pos + 1'b1;
        case (ph)
            P_TAG0: begin
                rec_base = pos;
                cur_tag  = {24'h0, b};
                tag_cnt  = 3'd1;
                len_acc  = '0;
                ph = ((b & dertlv_pkg::TAG_MORE_MASK) == dertlv_pkg::TAG_MORE_MASK) ?
                     P_TAGN : P_LEN0;
                return 1'b0;
            end
            P_TAGN: begin
                if (tag_cnt >= MAX_TAG) return kill_buffer(r);
                if (tag_cnt == 3'd1 && (b & dertlv_pkg::LOW7_MASK) == 0)
                    return kill_buffer(r);
                cur_tag = {cur_tag[dertlv_pkg::TAG_W-9:0], b};
                tag_cnt = tag_cnt + 1'b1;
                if ((b & dertlv_pkg::HIGH_BIT_MASK) == 0) ph = P_LEN0;
                return 1'b0;
            end
            P_LEN0: begin
                if ((b & dertlv_pkg::HIGH_BIT_MASK) == 0) begin
                    len_acc = {8'h0, b};
                    return header_end(pos, r);
                end
                n = b & dertlv_pkg::LOW7_MASK;
                if (n == 0 || n > MAX_LEN) return kill_buffer(r);
                len_left  = n[3:0];
                len_first = 1'b1;
                len_acc   = '0;
                ph        = P_LENN;
                return 1'b0;
            end
            P_LENN: begin
                // DER forbids a leading zero octet in a long-form length.
                if (len_first && b == 0) return kill_buffer(r);
                len_first = 1'b0;
                if (len_acc > (OFS_MAX >> 8)) return kill_buffer(r);
                len_acc  = {len_acc[dertlv_pkg::FIELD_W-9:0], b};
                len_left = len_left - 1'b1;
                if (len_left != 0) return 1'b0;
                // Long form is only legal where short form cannot say it.
                if (len_acc < dertlv_pkg::LONG_MIN) return kill_buffer(r);
                return header_end(pos, r);
            end
            P_VALUE: begin
                val_left = val_left - 1'b1;
                if (val_left == 0) return close_record(pos, r);
                return 1'b0;
            end
            default: return kill_buffer(r);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                 res_count, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers, all of which append to the pending queue.
    // ------------------------------------------------------------------
    task automatic queue_beat(input bit hold, input logic is_end, input logic [7:0] data);
        t_in_beat it;
        it.hold   = hold;
        it.is_end = is_end;
        it.data   = data;
        pending_q.push_back(it);
        if (counting && !hold) live_items++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        queue_beat(1'b0, 1'b0, b);
    endtask

    // The data byte of an end marker is meaningless, so it is random.
    task automatic put_end();
        queue_beat(1'b0, 1'b1, 8'($urandom_range(255)));
    endtask

    task automatic put_hold();
        queue_beat(1'b1, 1'b0, 8'h00);
    endtask

    // A legal tag: mostly single octet, otherwise two up to the maximum.
    task automatic put_tag();
        int         n;
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if ($urandom_range(3) != 0) begin
            if (b[4:0] == 5'h1f) b[4:0] = 5'($urandom_range(30));
            put_byte(b);
        end else begin
            n = $urandom_range(MAX_TAG, 2);
            b[4:0] = 5'h1f;
            put_byte(b);
            for (int i = 1; i < n; i++) begin
                b = 8'($urandom_range(255));
                b[7] = (i < n - 1);
                if (i == 1 && b[6:0] == 0) b[6:0] = 7'($urandom_range(127, 1));
                put_byte(b);
            end
        end
    endtask

    // A minimal DER length and its value bytes. Short values dominate so
    // that records, and with them results, come often.
    task automatic put_len_value();
        int r;
        int len;
        r = $urandom_range(39);
        if (r < 30)      len = $urandom_range(12, 0);
        else if (r < 35) len = $urandom_range(127, 13);
        else if (r < 39) len = $urandom_range(200, 128);
        else             len = $urandom_range(300, 256);
        if (len < 128) begin
            put_byte(8'(len));
        end else if (len < 256) begin
            put_byte(8'h81);
            put_byte(8'(len));
        end else begin
            put_byte(8'h82);
            put_byte(8'(len >> 8));
            put_byte(8'(len));
        end
        for (int i = 0; i < len; i++) put_byte(8'($urandom_range(255)));
    endtask

    // A broken or unfinished record of one of several kinds, followed by a few
    // bytes that the parser ignores only where the record already broke a rule.
    task automatic put_break();
        int         kind;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(8);
        case (kind)
            0: begin                            // value cut short, unless trailing bytes fill it
                put_tag();
                n = $urandom_range(10, 1);
                put_byte(8'(n));
                n = $urandom_range(n - 1);
                for (int i = 0; i < n; i++) put_byte(8'($urandom_range(255)));
            end
            1: put_tag();                       // tag, then only the trailing bytes
            2: begin                            // first continuation octet empty
                b = 8'($urandom_range(255));
                b[4:0] = 5'h1f;
                put_byte(b);
                put_byte({1'($urandom_range(1)), 7'h00});
            end
            3: begin                            // tag longer than allowed
                b = 8'($urandom_range(255));
                b[4:0] = 5'h1f;
                put_byte(b);
                for (int i = 1; i < MAX_TAG; i++) put_byte(8'($urandom_range(255, 129)));
                put_byte(8'($urandom_range(255)));
            end
            4: begin                            // indefinite length octet
                put_tag();
                put_byte(8'h80);
            end
            5: begin                            // too many length octets
                put_tag();
                put_byte(8'($urandom_range(255, 8'h80 + MAX_LEN + 1)));
            end
            6: begin                            // leading zero length octet
                put_tag();
                put_byte(8'($urandom_range(8'h80 + MAX_LEN, 8'h81)));
                put_byte(8'h00);
            end
            7: begin                            // long form holding a short length
                put_tag();
                put_byte(8'h81);
                put_byte(8'($urandom_range(127, 1)));
            end
            default: begin                      // length beyond the offset range
                put_tag();
                n = $urandom_range(MAX_LEN, 3);
                put_byte(8'(8'h80 + n));
                put_byte(8'($urandom_range(255, 1)));
                for (int i = 1; i < n; i++) put_byte(8'($urandom_range(255)));
            end
        endcase
        counting = 1'b0;
        n = $urandom_range(5);
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(255)));
        counting = 1'b1;
    endtask

    // One buffer: pure noise now and then, otherwise a few good records,
    // sometimes followed by a broken one, and always an end marker.
    task automatic put_buffer();
        int r;
        int n;
        r = $urandom_range(9);
        if (r == 0) begin
            n = $urandom_range(8, 1);
            for (int i = 0; i < n; i++) put_byte(8'($urandom_range(255)));
        end else begin
            n = $urandom_range(4);
            for (int i = 0; i < n; i++) begin
                put_tag();
                put_len_value();
            end
            if (r <= 3) put_break();
        end
        put_end();
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the pending beats on the slave side and throttles the
    // master side, both changing on the falling edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_p
        logic        nv;
        logic [7:0]  nd;
        logic        nu;
        cyc_count++;
        nv = s_axis_tvalid;
        nd = s_axis_tdata;
        nu = s_axis_tuser;
        if (i_rst_n) begin
            // A beat once offered stays until the parser takes it.
            if (!s_axis_tvalid || in_taken) begin
                nv = 1'b0;
                if (pending_q.size() != 0 && pending_q[0].hold) begin
                    if (record_q.size() == 0) pending_q.delete(0);
                end else if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
                    nv = 1'b1;
                    nd = pending_q[0].data;
                    nu = pending_q[0].is_end;
                    pending_q.delete(0);
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 24);
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
        s_axis_tuser  <= nu;
    end

    // ------------------------------------------------------------------
    // Monitor: on each rising edge, checks a taken result beat against the
    // oldest expected record, then feeds a taken input beat to the
    // predictor. The result taken now always stems from an earlier input
    // beat, so the order of the two steps is safe.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_p
        t_tlv_rec got;
        t_tlv_rec want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.tag    = m_axis_tdata[31:0];
                got.vlen   = m_axis_tdata[47:32];
                got.voff   = m_axis_tdata[63:48];
                got.enc    = m_axis_tdata[79:64];
                if (record_q.size() == 0) begin
                    report_mismatch("result beat with none expected, status",
                                    32'(got.status), 32'h0);
                end else begin
                    want = record_q.pop_front();
                    check_field("status", 32'(got.status), 32'(want.status));
                    check_field("tag", got.tag, want.tag);
                    check_field("val_len", 32'(got.vlen), 32'(want.vlen));
                    check_field("value_offset", 32'(got.voff), 32'(want.voff));
                    check_field("total_len", 32'(got.enc), 32'(want.enc));
                end
                res_count++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_taken = 1'b1;
                if (parse_beat(s_axis_tuser, s_axis_tdata, want)) record_q.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed buffers, then random buffers.
    // ------------------------------------------------------------------
    initial begin : main_p
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        reset_parser();

        // An empty buffer gives a clean end.
        put_end();
        // Tag zero with zero length, then the widest tag with a one-byte value.
        put_byte(8'h00); put_byte(8'h00);
        put_byte(8'h1f); put_byte(8'hff); put_byte(8'hff); put_byte(8'h7f);
        put_byte(8'h01); put_byte(8'hff);
        put_end();
        // Tag one octet too long, a byte that is ignored, then a silent end.
        put_byte(8'h1f); put_byte(8'h81); put_byte(8'h81); put_byte(8'h81);
        put_byte(8'h01); put_byte(8'haa);
        put_end();
        // First continuation octet with nothing in its low seven bits.
        put_byte(8'h3f); put_byte(8'h80); put_end();
        // Long form with no length octets, and one with too many.
        put_byte(8'h04); put_byte(8'h80); put_end();
        put_byte(8'h04); put_byte(8'h89); put_end();
        // Leading zero length octet, and a long form that should be short.
        put_byte(8'h04); put_byte(8'h82); put_byte(8'h00); put_end();
        put_byte(8'h04); put_byte(8'h81); put_byte(8'h7f); put_end();
        // A length too large for the offset range.
        put_byte(8'h04); put_byte(8'h83); put_byte(8'h01); put_byte(8'h00);
        put_byte(8'h00); put_end();
        // A record cut short, and an end marker in the middle of a tag.
        put_byte(8'h04); put_byte(8'h02); put_byte(8'h11); put_end();
        put_byte(8'h1f); put_end();
        put_hold();

        while (live_items < 1850) put_buffer();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (record_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (record_q.size() != 0)
            report_mismatch("records still expected", 32'(record_q.size()), 32'h0);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // A time bound far beyond the length of the run; reaching it is a failure.
    initial begin : limit_p
        #100000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dertlv_pkg.sv
rtl/der_tlv_stream_parser.sv
test/tb_der_tlv_stream_parser.sv
